### rtl/hbp_pkg.sv
// shared constants and request mode codes for the huffman bit packer
package hbp_pkg;

   localparam int BYTE_BITS = 8;
   localparam int BUF_W     = BYTE_BITS - 1;
   localparam int BCNT_W    = $clog2(BYTE_BITS);
   localparam int SYM_W     = 8;
   localparam int LEN_W     = 6;
   localparam int CODE_W    = 32;

   localparam int DEF_SYMBOL_COUNT = 128;
   localparam int DEF_MAX_CODE_LEN = 32;

   localparam logic [1:0] MODE_LOAD   = 2'd0;
   localparam logic [1:0] MODE_ENCODE = 2'd1;
   localparam logic [1:0] MODE_FLUSH  = 2'd2;

endpackage

### rtl/huffman_bit_packer_core.sv
// top level of the table-driven huffman bit packer
//
// Table-driven huffman encoder. A load request (mode 0) writes one entry of
// the code table: a length of 0 to MAX_CODE_LEN (larger lengths saturate)
// and the code bits, right-aligned, first bit at position length-1; loads to
// an index at or above SYMBOL_COUNT are dropped. An encode request (mode 1)
// looks up the symbol's code and appends it, msb first, to the pending bits;
// every completed byte is returned, earliest bit in the msb, so one encode
// gives zero to four responses, the final one carrying last. An encode of a
// symbol at or above SYMBOL_COUNT gives a single response with bad_symbol set
// and a zero byte, leaving the pending bits alone. A flush (mode 2) returns
// one byte, the pending bits padded with zeros on the right (a zero byte when
// nothing is pending), with last set, and clears the pending bits. Mode 3 is
// dropped. An encode goes through a table read, a merge, then one byte per
// cycle while the response consumer keeps up. The merge and the byte
// extraction share one wide shifter, and the byte loop is paced by the
// response register, so a stalled response consumer holds it up.
// The table holds per-entry valid bits cleared at reset, so no clearing pass
// is needed and requests are taken from the first cycle after reset.
module huffman_bit_packer_core #(
   parameter int SYMBOL_COUNT = hbp_pkg::DEF_SYMBOL_COUNT,
   parameter int MAX_CODE_LEN = hbp_pkg::DEF_MAX_CODE_LEN
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       req_mode,
   input  logic [hbp_pkg::SYM_W-1:0]        req_symbol,
   input  logic [hbp_pkg::LEN_W-1:0]        req_code_length,
   input  logic [hbp_pkg::CODE_W-1:0]       req_code_bits,

   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [hbp_pkg::BYTE_BITS-1:0]    rsp_out_byte,
   output logic                             rsp_last,
   output logic                             rsp_bad_symbol
);

   localparam int IDX_W = $clog2(SYMBOL_COUNT);
   // pending bits plus one whole code
   localparam int ACC_W = MAX_CODE_LEN + hbp_pkg::BUF_W;
   localparam int CNT_W = $clog2(ACC_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MERGE,
      ST_EMIT,
      ST_SEND
   } state_type;

   state_type state_ff, state_in;

   logic [hbp_pkg::BUF_W-1:0]     buf_ff, buf_in;
   logic [hbp_pkg::BCNT_W-1:0]    cnt_ff, cnt_in;
   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic [CNT_W-1:0]              tot_ff, tot_in;
   logic [hbp_pkg::BYTE_BITS-1:0] hold_byte_ff, hold_byte_in;
   logic                          hold_bad_ff, hold_bad_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [hbp_pkg::BYTE_BITS-1:0] rsp_byte_ff, rsp_byte_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic                          rsp_bad_ff, rsp_bad_in;

   logic                          req_fire;
   logic                          sym_in_range;
   logic [hbp_pkg::LEN_W-1:0]     len_sat;
   logic                          tbl_wr_en;
   logic                          tbl_rd_en;
   logic [hbp_pkg::LEN_W-1:0]     tbl_len;
   logic [MAX_CODE_LEN-1:0]       tbl_code;
   logic [MAX_CODE_LEN-1:0]       code_mask;

   logic [ACC_W-1:0]              sh_val;
   logic [CNT_W-1:0]              sh_amt;
   logic [ACC_W-1:0]              sh_out;
   logic [ACC_W-1:0]              merged;
   logic [CNT_W-1:0]              merged_tot;
   logic [CNT_W-1:0]              rem;
   logic                          rem_last;
   logic [hbp_pkg::BUF_W-1:0]     rem_mask;
   logic [hbp_pkg::BYTE_BITS-1:0] flush_byte;
   logic                          rsp_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;

   assign sym_in_range = ({1'b0, req_symbol} < (hbp_pkg::SYM_W + 1)'(SYMBOL_COUNT));
   assign len_sat = (req_code_length > hbp_pkg::LEN_W'(MAX_CODE_LEN)) ?
                    hbp_pkg::LEN_W'(MAX_CODE_LEN) : req_code_length;

   assign tbl_wr_en = req_fire && (req_mode == hbp_pkg::MODE_LOAD) && sym_in_range;
   assign tbl_rd_en = req_fire && (req_mode == hbp_pkg::MODE_ENCODE) && sym_in_range;

   hbp_table #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .IDX_W        (IDX_W)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tbl_wr_en),
      .wr_idx  (req_symbol[IDX_W-1:0]),
      .wr_len  (len_sat),
      .wr_code (req_code_bits[MAX_CODE_LEN-1:0]),
      .rd_en   (tbl_rd_en),
      .rd_idx  (req_symbol[IDX_W-1:0]),
      .rd_len  (tbl_len),
      .rd_code (tbl_code)
   );

   // shared shifter: merge moves the pending bits up by the code length,
   // emit lines the next byte up with the top of the accumulator
   assign sh_val = (state_ff == ST_MERGE) ? ACC_W'(buf_ff) : acc_ff;
   assign sh_amt = (state_ff == ST_MERGE) ? CNT_W'(tbl_len) : (CNT_W'(ACC_W) - tot_ff);
   assign sh_out = sh_val << sh_amt;

   // bits above the code length are dropped
   assign code_mask  = ~({MAX_CODE_LEN{1'b1}} << tbl_len);
   assign merged     = sh_out | ACC_W'(tbl_code & code_mask);
   assign merged_tot = CNT_W'(cnt_ff) + CNT_W'(tbl_len);

   assign rem      = tot_ff - CNT_W'(hbp_pkg::BYTE_BITS);
   assign rem_last = (rem < CNT_W'(hbp_pkg::BYTE_BITS));
   assign rem_mask = ~({hbp_pkg::BUF_W{1'b1}} << rem);

   // pending bits padded with zeros on the right, zero when nothing pending
   assign flush_byte = hbp_pkg::BYTE_BITS'(buf_ff) <<
                       ((hbp_pkg::BCNT_W + 1)'(hbp_pkg::BYTE_BITS) - {1'b0, cnt_ff});

   always_comb begin
      state_in     = state_ff;
      buf_in       = buf_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      tot_in       = tot_ff;
      hold_byte_in = hold_byte_ff;
      hold_bad_in  = hold_bad_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_bad_in   = rsp_bad_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_mode == hbp_pkg::MODE_ENCODE) begin
                  if (sym_in_range) begin
                     state_in = ST_MERGE;
                  end else begin
                     // bad symbol, pending bits untouched
                     hold_byte_in = '0;
                     hold_bad_in  = 1'b1;
                     state_in     = ST_SEND;
                  end
               end else if (req_mode == hbp_pkg::MODE_FLUSH) begin
                  hold_byte_in = flush_byte;
                  hold_bad_in  = 1'b0;
                  buf_in       = '0;
                  cnt_in       = '0;
                  state_in     = ST_SEND;
               end
            end
         end

         ST_MERGE: begin
            if (merged_tot < CNT_W'(hbp_pkg::BYTE_BITS)) begin
               // no full byte, the merged bits become the new pending bits
               buf_in   = merged[hbp_pkg::BUF_W-1:0];
               cnt_in   = merged_tot[hbp_pkg::BCNT_W-1:0];
               state_in = ST_IDLE;
            end else begin
               acc_in   = merged;
               tot_in   = merged_tot;
               state_in = ST_EMIT;
            end
         end

         ST_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = sh_out[ACC_W-1 -: hbp_pkg::BYTE_BITS];
               rsp_last_in  = rem_last;
               rsp_bad_in   = 1'b0;
               tot_in       = rem;
               if (rem_last) begin
                  buf_in   = acc_ff[hbp_pkg::BUF_W-1:0] & rem_mask;
                  cnt_in   = rem[hbp_pkg::BCNT_W-1:0];
                  state_in = ST_IDLE;
               end
            end
         end

         ST_SEND: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = hold_byte_ff;
               rsp_last_in  = 1'b1;
               rsp_bad_in   = hold_bad_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         buf_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_ff       <= buf_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      // payload, no reset
      acc_ff       <= acc_in;
      tot_ff       <= tot_in;
      hold_byte_ff <= hold_byte_in;
      hold_bad_ff  <= hold_bad_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_bad_symbol = rsp_bad_ff;

   // the byte loop only runs while a whole byte is in hand
   a_emit_has_byte: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) |-> (tot_ff >= CNT_W'(hbp_pkg::BYTE_BITS)))
      else $error("byte loop entered without a full byte");

   // a bad symbol response carries a zero byte
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_byte_ff == '0))
      else $error("bad symbol response with non-zero byte");

   // a flush leaves nothing pending
   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == hbp_pkg::MODE_FLUSH)) |=> ((cnt_ff == '0) && (buf_ff == '0)))
      else $error("pending bits survive a flush");

   // a load never produces a response
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_mode == hbp_pkg::MODE_LOAD) && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("load request produced a response");

endmodule

### rtl/hbp_table.sv
// code table: length and code memories with per-entry valid bits for the lengths
module hbp_table #(
   parameter int SYMBOL_COUNT = hbp_pkg::DEF_SYMBOL_COUNT,
   parameter int MAX_CODE_LEN = hbp_pkg::DEF_MAX_CODE_LEN,
   parameter int IDX_W        = $clog2(SYMBOL_COUNT)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [hbp_pkg::LEN_W-1:0]   wr_len,
   input  logic [MAX_CODE_LEN-1:0]     wr_code,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_idx,
   output logic [hbp_pkg::LEN_W-1:0]   rd_len,
   output logic [MAX_CODE_LEN-1:0]     rd_code
);

   logic [hbp_pkg::LEN_W-1:0] len_mem [SYMBOL_COUNT];
   logic [MAX_CODE_LEN-1:0]   code_mem [SYMBOL_COUNT];
   logic [SYMBOL_COUNT-1:0]   valid_ff;

   logic [hbp_pkg::LEN_W-1:0] len_rd_ff;
   logic [MAX_CODE_LEN-1:0]   code_rd_ff;
   logic                      vld_rd_ff;

   // memories, no reset
   always_ff @(posedge clock) begin
      if (wr_en) begin
         len_mem[wr_idx]  <= wr_len;
         code_mem[wr_idx] <= wr_code;
      end
      if (rd_en) begin
         len_rd_ff  <= len_mem[rd_idx];
         code_rd_ff <= code_mem[rd_idx];
      end
   end

   // unwritten entries read as zero length
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         vld_rd_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_idx] <= 1'b1;
         end
         if (rd_en) begin
            vld_rd_ff <= valid_ff[rd_idx];
         end
      end
   end

   assign rd_len  = vld_rd_ff ? len_rd_ff : '0;
   assign rd_code = code_rd_ff;

endmodule
